@@ hw/rtl/tgkd_pkg.sv @@
// touch gesture key decoder: shared types, constants and register map
// used by tgkd_regs, tgkd_step and touch_gesture_key_decoder_core
`default_nettype none

package tgkd_pkg;

  localparam int COUNT_BITS = 8;
  localparam int TIME_BITS  = 32;
  localparam int ADDR_BITS  = 4;
  localparam int DATA_BITS  = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_THRMAX = COUNT_MAX - COUNT_BITS'(1);

  localparam logic [7:0]  LONG_PRESS_RESET = 8'd15;
  localparam logic [15:0] LOCKOUT_RESET    = 16'd300;

  typedef enum logic [1:0] {
    CMD_TOUCH   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_SET     = 2'd2,
    CMD_POLL    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    LED_KEEP = 2'd0,
    LED_ON   = 2'd1,
    LED_OFF  = 2'd2
  } led_e;

  typedef enum logic [1:0] {
    REG_ENABLE     = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_LOCKOUT    = 2'd2
  } reg_e;

  // key codes
  localparam logic [2:0] KEY_UP      = 3'd0;
  localparam logic [2:0] KEY_DOWN    = 3'd1;
  localparam logic [2:0] KEY_LEFT    = 3'd2;
  localparam logic [2:0] KEY_RIGHT   = 3'd3;
  localparam logic [2:0] KEY_SET     = 3'd4;
  localparam logic [2:0] KEY_Q       = 3'd5;
  localparam logic [2:0] KEY_MENU    = 3'd6;
  localparam logic [2:0] KEY_RELEASE = 3'd7;

  // stored direction: none, else direction + 1
  localparam logic [2:0] DIR_NONE = 3'd0;

  typedef struct packed {
    logic        enable;
    logic [7:0]  long_press_ticks;
    logic [15:0] set_lockout_ms;
  } cfg_t;

  typedef struct packed {
    cmd_e                 cmd;
    logic [1:0]           direction;
    logic                 synthetic;
    logic                 menu_shown;
    logic [TIME_BITS-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic                  touching;
    logic [COUNT_BITS-1:0] hold_count;
    logic [2:0]            current_dir;
    logic [2:0]            previous_dir;
    logic                  lockout_armed;
    logic [TIME_BITS-1:0]  lockout_start;
    logic                  polling;
  } state_t;

  typedef struct packed {
    logic       pass_on;
    logic       key_valid;
    logic [2:0] key_code;
    led_e       led_action;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/tgkd_regs.sv @@
// touch gesture key decoder: apb configuration registers
// depends on tgkd_pkg
`default_nettype none

module tgkd_regs
  import tgkd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg_o,
  output logic                      clear_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  reg_e idx;

  assign idx    = reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d   = cfg_q;
    clear_o = 1'b0;
    if (wr_en) begin
      case (idx)
        REG_ENABLE: begin
          cfg_d.enable = pwdata[0];
          clear_o      = pwdata[0];
        end
        REG_LONG_PRESS: cfg_d.long_press_ticks = pwdata[7:0];
        REG_LOCKOUT:    cfg_d.set_lockout_ms   = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable           <= 1'b0;
      cfg_q.long_press_ticks <= LONG_PRESS_RESET;
      cfg_q.set_lockout_ms   <= LOCKOUT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE:     prdata = DATA_BITS'(cfg_q.enable);
      REG_LONG_PRESS: prdata = DATA_BITS'(cfg_q.long_press_ticks);
      REG_LOCKOUT:    prdata = DATA_BITS'(cfg_q.set_lockout_ms);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/tgkd_step.sv @@
// touch gesture key decoder: next-state and result logic for one transaction
// depends on tgkd_pkg
`default_nettype none

module tgkd_step
  import tgkd_pkg::*;
(
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  state_t  state_i,
  output state_t  state_o,
  output result_t res_o
);

  logic [TIME_BITS-1:0]  elapsed;
  logic                  locked;
  logic [COUNT_BITS-1:0] thr;
  logic [COUNT_BITS-1:0] hold;
  logic [1:0]            prev_code;
  logic [2:0]            cur_code;

  assign elapsed   = item_i.now_ms - state_i.lockout_start;
  assign locked    = state_i.lockout_armed && (elapsed < TIME_BITS'(cfg_i.set_lockout_ms));
  assign prev_code = 2'(state_i.previous_dir - 3'd1);
  assign cur_code  = state_i.current_dir - 3'd1;

  // clamp threshold so a fired long press never matches again
  always_comb begin
    if (17'(cfg_i.long_press_ticks) > 17'(COUNT_THRMAX)) begin
      thr = COUNT_THRMAX;
    end else begin
      thr = COUNT_BITS'(cfg_i.long_press_ticks);
    end
  end

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    hold    = state_i.hold_count;
    if (item_i.cmd != CMD_POLL) begin
      if (!cfg_i.enable || item_i.synthetic) begin
        res_o.pass_on = 1'b1;
      end else begin
        case (item_i.cmd)
          CMD_TOUCH: begin
            state_o.touching     = 1'b1;
            state_o.hold_count   = '0;
            state_o.previous_dir = state_i.current_dir;
            state_o.current_dir  = 3'(item_i.direction) + 3'd1;
            state_o.polling      = 1'b1;
            res_o.led_action     = LED_ON;
          end
          CMD_RELEASE: begin
            state_o.touching      = 1'b0;
            state_o.current_dir   = DIR_NONE;
            state_o.previous_dir  = DIR_NONE;
            state_o.lockout_armed = 1'b0;
            state_o.lockout_start = '0;
            res_o.led_action      = LED_OFF;
          end
          default: begin
            state_o.lockout_armed = 1'b1;
            state_o.lockout_start = item_i.now_ms;
            res_o.led_action      = LED_OFF;
            res_o.pass_on         = 1'b1;
          end
        endcase
      end
    end else if (state_i.polling) begin
      if (state_i.touching && !locked) begin
        if (hold != COUNT_MAX) begin
          hold = hold + COUNT_BITS'(1);
        end
      end else begin
        state_o.polling = 1'b0;
        if (hold > thr) begin
          res_o.key_valid = 1'b1;
          res_o.key_code  = KEY_RELEASE;
        end
      end
      if (hold == thr) begin
        // plain single-direction long press
        if (state_i.current_dir != DIR_NONE && state_i.previous_dir == DIR_NONE) begin
          res_o.key_valid = 1'b1;
          res_o.key_code  = {1'b0, cur_code[1:0]};
        end
        hold = hold + COUNT_BITS'(1);
      end else if (state_i.previous_dir != DIR_NONE && hold < thr) begin
        // two-direction gesture
        if ((prev_code == KEY_UP[1:0] && cur_code == KEY_LEFT) ||
            (prev_code == KEY_LEFT[1:0] && cur_code == KEY_UP)) begin
          res_o.key_valid = 1'b1;
          res_o.key_code  = item_i.menu_shown ? KEY_Q : KEY_MENU;
        end else if ((prev_code == KEY_RIGHT[1:0] && cur_code == KEY_DOWN) ||
                     (prev_code == KEY_DOWN[1:0] && cur_code == KEY_RIGHT)) begin
          res_o.key_valid = 1'b1;
          res_o.key_code  = KEY_SET;
        end
        hold = thr + COUNT_BITS'(1);
      end
      state_o.hold_count = hold;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/touch_gesture_key_decoder_core.sv @@
// touch gesture key decoder top level: input register, step logic, result register
// depends on tgkd_pkg, tgkd_regs and tgkd_step
// path: input register, step logic, result register; a stalled result register holds the flow
// throughput: one transaction per cycle unless the result channel stalls; single-pass step logic
// reset: gesture state clear, enable 0, long press 15 ticks, lockout 300 ms
`default_nettype none

module touch_gesture_key_decoder_core
  import tgkd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           cmd_i,
  input  wire logic [1:0]           direction_i,
  input  wire logic                 synthetic_i,
  input  wire logic                 menu_shown_i,
  input  wire logic [31:0]          now_ms_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      pass_on_o,
  output logic                      key_valid_o,
  output logic [2:0]                key_code_o,
  output logic [1:0]                led_action_o
);

  cfg_t    cfg;
  logic    cfg_clear;

  // input register
  logic    in_valid_q;
  item_t   item_q;

  // gesture state
  state_t  state_q, state_d, state_nxt;

  // result register
  logic    out_valid_q;
  result_t res_q, res_nxt;

  logic    out_load;   // result register can take a new transaction
  logic    step_fire;  // input register hands its transaction to the step logic
  logic    in_load;

  tgkd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .clear_o (cfg_clear)
  );

  tgkd_step u_step (
    .cfg_i   (cfg),
    .item_i  (item_q),
    .state_i (state_q),
    .state_o (state_nxt),
    .res_o   (res_nxt)
  );

  // handshake: the input register drains whenever the result register is free
  // or its transaction is being taken this cycle
  assign out_load   = !out_valid_q || !out_stall_i;
  assign step_fire  = in_valid_q && out_load;
  assign in_stall_o = in_valid_q && !out_load;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      item_q.cmd        <= cmd_e'(cmd_i);
      item_q.direction  <= direction_i;
      item_q.synthetic  <= synthetic_i;
      item_q.menu_shown <= menu_shown_i;
      item_q.now_ms     <= now_ms_i[TIME_BITS-1:0];
    end
  end

  // gesture state: enabling clears it; config must only change while idle, not enforced here
  always_comb begin
    state_d = state_q;
    if (cfg_clear) begin
      state_d = '0;
    end else if (step_fire) begin
      state_d = state_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_q <= res_nxt;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pass_on_o    = res_q.pass_on;
  assign key_valid_o  = res_q.key_valid;
  assign key_code_o   = res_q.key_code;
  assign led_action_o = res_q.led_action;

  // a result without a key carries key code zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !key_valid_o |-> key_code_o == KEY_UP)
    else $error("key code set without key valid");

  // led action never takes the unused code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> led_action_o != 2'd3)
    else $error("invalid led action");

  // a transaction in the input register reaches the result register when not stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> out_valid_o)
    else $error("transaction lost between input and result register");

  // the input side only stalls while the result register is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free result register");

endmodule

`default_nettype wire

@@ test/tb_touch_gesture_key_decoder_core.sv @@
// testbench for touch_gesture_key_decoder_core: directed and random touch event streams,
// each result checked in order against a behavioral decoder held in a scoreboard class
// depends on tgkd_pkg and the decoder rtl

module tb_touch_gesture_key_decoder_core;
  import tgkd_pkg::*;

  // scoreboard: behavioral decoder plus the queue of key results still owed by the dut
  class key_scoreboard;
    logic        en;
    logic [7:0]  press_ticks;
    logic [15:0] lock_ms;
    state_t      st;
    result_t     keys_due_q[$];
    int unsigned errors;

    function new();
      en          = 1'b0;
      press_ticks = LONG_PRESS_RESET;
      lock_ms     = LOCKOUT_RESET;
      st          = '0;
      errors      = 0;
    endfunction

    function void write_reg(reg_e idx, logic [31:0] value);
      case (idx)
        REG_ENABLE: begin
          en = value[0];
          if (en) st = '0;
        end
        REG_LONG_PRESS: press_ticks = value[7:0];
        REG_LOCKOUT:    lock_ms = value[15:0];
        default: ;
      endcase
    endfunction

    // decode one accepted event and queue the key result it produces
    function void note_event(item_t it);
      result_t               r;
      logic [COUNT_BITS-1:0] thr;
      logic [TIME_BITS-1:0]  elapsed;
      logic                  locked;
      logic [2:0]            pd;
      logic [2:0]            c;
      r   = '0;
      thr = (press_ticks > COUNT_THRMAX) ? COUNT_THRMAX : press_ticks;
      if (it.cmd != CMD_POLL) begin
        if (!en || it.synthetic) begin
          r.pass_on = 1'b1;
        end else if (it.cmd == CMD_TOUCH) begin
          st.touching     = 1'b1;
          st.hold_count   = '0;
          st.previous_dir = st.current_dir;
          st.current_dir  = {1'b0, it.direction} + 3'd1;
          st.polling      = 1'b1;
          r.led_action    = LED_ON;
        end else if (it.cmd == CMD_RELEASE) begin
          st.touching      = 1'b0;
          st.current_dir   = DIR_NONE;
          st.previous_dir  = DIR_NONE;
          st.lockout_armed = 1'b0;
          st.lockout_start = '0;
          r.led_action     = LED_OFF;
        end else begin
          st.lockout_armed = 1'b1;
          st.lockout_start = it.now_ms;
          r.led_action     = LED_OFF;
          r.pass_on        = 1'b1;
        end
      end else if (st.polling) begin
        elapsed = it.now_ms - st.lockout_start;
        locked  = st.lockout_armed && (elapsed < TIME_BITS'(lock_ms));
        if (st.touching && !locked) begin
          if (st.hold_count != COUNT_MAX) st.hold_count++;
        end else begin
          st.polling = 1'b0;
          if (st.hold_count > thr) begin
            r.key_valid = 1'b1;
            r.key_code  = KEY_RELEASE;
          end
        end
        if (st.hold_count == thr) begin
          if (st.current_dir != DIR_NONE && st.previous_dir == DIR_NONE) begin
            c           = st.current_dir - 3'd1;
            r.key_valid = 1'b1;
            r.key_code  = {1'b0, c[1:0]};
          end
          st.hold_count++;
        end else if (st.previous_dir != DIR_NONE && st.hold_count < thr) begin
          pd = st.previous_dir - 3'd1;
          pd = {1'b0, pd[1:0]};
          c  = st.current_dir - 3'd1;
          if ((pd == KEY_UP && c == KEY_LEFT) || (pd == KEY_LEFT && c == KEY_UP)) begin
            r.key_valid = 1'b1;
            r.key_code  = it.menu_shown ? KEY_Q : KEY_MENU;
          end else if ((pd == KEY_RIGHT && c == KEY_DOWN) ||
                       (pd == KEY_DOWN && c == KEY_RIGHT)) begin
            r.key_valid = 1'b1;
            r.key_code  = KEY_SET;
          end
          st.hold_count = thr + COUNT_BITS'(1);
        end
      end
      keys_due_q.push_back(r);
    endfunction

    function void field_ok(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (keys_due_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none actual %p", $time, got);
        return;
      end
      want = keys_due_q.pop_front();
      field_ok("pass_on", 3'(want.pass_on), 3'(got.pass_on));
      field_ok("key_valid", 3'(want.key_valid), 3'(got.key_valid));
      field_ok("key_code", want.key_code, got.key_code);
      field_ok("led_action", 3'(want.led_action), 3'(got.led_action));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           cmd_i;
  logic [1:0]           direction_i;
  logic                 synthetic_i;
  logic                 menu_shown_i;
  logic [31:0]          now_ms_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 pass_on_o;
  logic                 key_valid_o;
  logic [2:0]           key_code_o;
  logic [1:0]           led_action_o;

  key_scoreboard sb;
  int unsigned   items_sent;
  int unsigned   burst_left;
  logic [31:0]   ms_now;

  touch_gesture_key_decoder_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .direction_i  (direction_i),
    .synthetic_i  (synthetic_i),
    .menu_shown_i (menu_shown_i),
    .now_ms_i     (now_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pass_on_o    (pass_on_o),
    .key_valid_o  (key_valid_o),
    .key_code_o   (key_code_o),
    .led_action_o (led_action_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop in case a transaction never completes
  initial begin
    #3600000;
    $display("Verification failed");
    $finish;
  end

  // receiver: stall pattern changes mode after each random-length segment, mode 0 never stalls
  initial begin
    int unsigned seg;
    int unsigned mode;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      seg  = $urandom_range(1, 40);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        @(negedge clk_i);
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= 1'($urandom_range(0, 1));
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // result monitor: every accepted result transaction goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result({pass_on_o, key_valid_o, key_code_o, led_e'(led_action_o)});
    end
  end

  // millisecond clock moves forward a little with every event, like 20 ms poll ticks
  function automatic logic [31:0] next_ms();
    ms_now = ms_now + $urandom_range(0, 40);
    return ms_now;
  endfunction

  function automatic item_t mk(cmd_e c, logic [1:0] d, logic s, logic m, logic [31:0] t);
    item_t it;
    it.cmd        = c;
    it.direction  = d;
    it.synthetic  = s;
    it.menu_shown = m;
    it.now_ms     = t;
    return it;
  endfunction

  // software-made events are rare in the random part
  function automatic logic synth_bit();
    return ($urandom_range(0, 9) == 0);
  endfunction

  // register write: setup cycle then access cycle, called at a falling edge
  task automatic write_reg(input reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'(4 * int'(idx));
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // sender: bursts of random length with random gaps, called at a falling edge
  task automatic send_item(input item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    cmd_i        <= it.cmd;
    direction_i  <= it.direction;
    synthetic_i  <= it.synthetic;
    menu_shown_i <= it.menu_shown;
    now_ms_i     <= it.now_ms;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_event(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  // stop sending and let every pending result come out
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.keys_due_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // random traffic: mostly complete touch-hold-release gestures, the rest noise
  task automatic random_phase(input int unsigned n);
    int unsigned stop_at;
    int unsigned thr;
    int unsigned polls;
    stop_at = items_sent + n;
    // keep holds short when the threshold is large
    thr = (sb.press_ticks > 8) ? 8 : sb.press_ticks;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          send_item(mk(CMD_TOUCH, 2'($urandom), synth_bit(), 1'($urandom), next_ms()));
          // second direction makes a gesture candidate
          if ($urandom_range(0, 1))
            send_item(mk(CMD_TOUCH, 2'($urandom), synth_bit(), 1'($urandom), next_ms()));
          polls = $urandom_range(0, thr + 3);
          repeat (polls) begin
            if ($urandom_range(0, 15) == 0)
              send_item(mk(CMD_SET, 2'($urandom), synth_bit(), 1'($urandom), next_ms()));
            send_item(mk(CMD_POLL, 2'($urandom), 1'($urandom), 1'($urandom), next_ms()));
          end
          send_item(mk(CMD_RELEASE, 2'($urandom), synth_bit(), 1'($urandom), next_ms()));
          repeat ($urandom_range(0, 2))
            send_item(mk(CMD_POLL, 2'($urandom), 1'($urandom), 1'($urandom), next_ms()));
        end
        6, 7: begin
          send_item(mk(cmd_e'($urandom_range(0, 3)), 2'($urandom), 1'($urandom),
                       1'($urandom), next_ms()));
        end
        8: begin
          // set button then a touch: counting runs into the lockout window
          send_item(mk(CMD_SET, 2'($urandom), synth_bit(), 1'($urandom), next_ms()));
          send_item(mk(CMD_TOUCH, 2'($urandom), synth_bit(), 1'($urandom), next_ms()));
          repeat ($urandom_range(0, thr + 2))
            send_item(mk(CMD_POLL, 2'($urandom), 1'($urandom), 1'($urandom), next_ms()));
        end
        default: begin
          // clock jump anywhere in the 32 bit range, wrap included
          ms_now = $urandom;
          send_item(mk(CMD_POLL, 2'($urandom), 1'($urandom), 1'($urandom), next_ms()));
        end
      endcase
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    cmd_i        = CMD_TOUCH;
    direction_i  = '0;
    synthetic_i  = 1'b0;
    menu_shown_i = 1'b0;
    now_ms_i     = '0;
    items_sent   = 0;
    burst_left   = 0;
    ms_now       = 32'd1000;
    sb           = new();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // after reset the decoder is off: everything passes on, polls are ignored
    send_item(mk(CMD_TOUCH, 2'd3, 1'b0, 1'b0, next_ms()));
    send_item(mk(CMD_POLL, 2'd0, 1'b0, 1'b0, next_ms()));
    send_item(mk(CMD_SET, 2'd1, 1'b0, 1'b1, next_ms()));
    send_item(mk(CMD_RELEASE, 2'd2, 1'b0, 1'b0, next_ms()));
    send_item(mk(CMD_TOUCH, 2'd1, 1'b1, 1'b1, next_ms()));
    drain();

    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_LONG_PRESS, 32'd2);
    write_reg(REG_LOCKOUT, 32'd100);

    // plain long press on up, then release key after the hold ends
    send_item(mk(CMD_TOUCH, 2'd0, 1'b0, 1'b0, next_ms()));
    send_item(mk(CMD_POLL, 2'd0, 1'b0, 1'b0, next_ms()));
    send_item(mk(CMD_POLL, 2'd0, 1'b0, 1'b0, next_ms()));
    send_item(mk(CMD_POLL, 2'd0, 1'b0, 1'b0, next_ms()));
    send_item(mk(CMD_RELEASE, 2'd0, 1'b0, 1'b0, next_ms()));
    send_item(mk(CMD_POLL, 2'd0, 1'b0, 1'b0, next_ms()));
    send_item(mk(CMD_POLL, 2'd0, 1'b0, 1'b0, next_ms()));
    // right then down gives set
    send_item(mk(CMD_TOUCH, 2'd3, 1'b0, 1'b0, next_ms()));
    send_item(mk(CMD_TOUCH, 2'd1, 1'b0, 1'b0, next_ms()));
    send_item(mk(CMD_POLL, 2'd0, 1'b0, 1'b0, next_ms()));
    send_item(mk(CMD_RELEASE, 2'd0, 1'b0, 1'b0, next_ms()));
    send_item(mk(CMD_POLL, 2'd0, 1'b0, 1'b0, next_ms()));
    // up then left with a menu shown gives q, left then up without gives menu
    send_item(mk(CMD_TOUCH, 2'd0, 1'b0, 1'b1, next_ms()));
    send_item(mk(CMD_TOUCH, 2'd2, 1'b0, 1'b1, next_ms()));
    send_item(mk(CMD_POLL, 2'd0, 1'b0, 1'b1, next_ms()));
    send_item(mk(CMD_TOUCH, 2'd0, 1'b0, 1'b0, next_ms()));
    send_item(mk(CMD_POLL, 2'd0, 1'b0, 1'b0, next_ms()));
    // up then down is no known gesture
    send_item(mk(CMD_TOUCH, 2'd1, 1'b0, 1'b0, next_ms()));
    send_item(mk(CMD_POLL, 2'd3, 1'b0, 1'b0, next_ms()));
    send_item(mk(CMD_RELEASE, 2'd0, 1'b0, 1'b0, next_ms()));
    // lockout window across the clock wrap stops the poll chain
    send_item(mk(CMD_SET, 2'd0, 1'b0, 1'b0, 32'hFFFF_FFF0));
    send_item(mk(CMD_TOUCH, 2'd3, 1'b0, 1'b0, 32'hFFFF_FFFA));
    send_item(mk(CMD_POLL, 2'd0, 1'b0, 1'b0, 32'h0000_0010));
    send_item(mk(CMD_POLL, 2'd0, 1'b0, 1'b0, 32'h0000_0200));
    // after the window counting works again, release disarms it
    send_item(mk(CMD_TOUCH, 2'd3, 1'b0, 1'b0, 32'h0000_0210));
    send_item(mk(CMD_POLL, 2'd0, 1'b0, 1'b0, 32'h0000_0230));
    send_item(mk(CMD_RELEASE, 2'd0, 1'b0, 1'b0, 32'h0000_0240));
    send_item(mk(CMD_TOUCH, 2'd2, 1'b1, 1'b0, 32'h0000_0250));
    send_item(mk(CMD_POLL, 2'd0, 1'b1, 1'b0, 32'hFFFF_FFFF));
    drain();

    // threshold zero with no lockout window
    ms_now = 32'h8000_0000;
    write_reg(REG_LONG_PRESS, 32'd0);
    write_reg(REG_LOCKOUT, 32'd0);
    random_phase(10);
    drain();

    // threshold above range is clamped, longest lockout window
    write_reg(REG_LONG_PRESS, 32'd255);
    write_reg(REG_LOCKOUT, 32'd65535);
    random_phase(10);
    drain();

    // largest legal threshold: one long hold runs into counter saturation
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_LONG_PRESS, 32'd254);
    write_reg(REG_LOCKOUT, 32'd300);
    send_item(mk(CMD_TOUCH, 2'd2, 1'b0, 1'b0, next_ms()));
    repeat (258) send_item(mk(CMD_POLL, 2'($urandom), 1'b0, 1'($urandom), next_ms()));
    send_item(mk(CMD_RELEASE, 2'd2, 1'b0, 1'b0, next_ms()));
    send_item(mk(CMD_POLL, 2'd0, 1'b0, 1'b0, next_ms()));
    drain();

    write_reg(REG_LONG_PRESS, 32'd1);
    write_reg(REG_LOCKOUT, 32'd20);
    random_phase(25);
    drain();

    // disabled with gesture state kept: running poll chains still tick
    write_reg(REG_ENABLE, 32'd0);
    random_phase(10);
    drain();

    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_LONG_PRESS, 32'($urandom_range(1, 6)));
    write_reg(REG_LOCKOUT, 32'($urandom_range(0, 400)));
    random_phase(25);
    drain();

    write_reg(REG_LONG_PRESS, 32'($urandom_range(1, 8)));
    write_reg(REG_LOCKOUT, 32'($urandom_range(0, 65535)));
    random_phase(25);
    drain();

    if (sb.errors == 0 && sb.keys_due_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ touch_gesture_key_decoder_core.f @@
hw/rtl/tgkd_pkg.sv
hw/rtl/tgkd_regs.sv
hw/rtl/tgkd_step.sv
hw/rtl/touch_gesture_key_decoder_core.sv
test/tb_touch_gesture_key_decoder_core.sv
